### rtl/core/pinhole_ray_direction_generator_macros.svh
// Assertion macros for the checker file of the ray direction block.
`ifndef PINHOLE_RAY_DIRECTION_GENERATOR_MACROS_SVH
`define PINHOLE_RAY_DIRECTION_GENERATOR_MACROS_SVH

// Checked at every rising edge outside reset.
`define PRDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PRDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/prdg_pkg.sv
// ----------------------------------------------------------------------------
// prdg_pkg
// Types, widths and register indexes of the pinhole ray direction generator.
// ----------------------------------------------------------------------------
package prdg_pkg;

  localparam int CoordBits = 12;
  localparam int SumW      = 50;   // vx^2 + vy^2 + vz^2 in Q.40
  localparam int LenW      = 25;   // square root of the sum, Q.20
  localparam int MagW      = 24;   // magnitude of a view-space component, Q.20
  localparam int NumW      = 42;   // dividend of the normalization
  localparam int QuotW     = 17;   // unit component magnitude, Q.16
  localparam int SqrtSteps = SumW / 2;
  localparam int DivSteps  = QuotW;
  // Register stages from an accepted item to its result on the ports.
  localparam int Latency   = 10 + SqrtSteps + DivSteps;

  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegRotX   = 3'd0;
  localparam logic [RegIdxW-1:0] RegRotY   = 3'd1;
  localparam logic [RegIdxW-1:0] RegRotZ   = 3'd2;
  localparam logic [RegIdxW-1:0] RegScaleX = 3'd3;
  localparam logic [RegIdxW-1:0] RegScaleY = 3'd4;
  localparam logic [RegIdxW-1:0] RegStepX  = 3'd5;
  localparam logic [RegIdxW-1:0] RegStepY  = 3'd6;

  localparam logic [47:0] RotXReset  = 48'h0000_0000_4000;
  localparam logic [47:0] RotYReset  = 48'h0000_4000_0000;
  localparam logic [47:0] RotZReset  = 48'h4000_0000_0000;
  localparam logic [15:0] ScaleReset = 16'd1697;
  localparam logic [17:0] StepReset  = 18'd256;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } dir_t;

endpackage

### rtl/core/prdg_sqrt.sv
// ----------------------------------------------------------------------------
// prdg_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module prdg_sqrt
  import prdg_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [SumW-1:0]   n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [LenW-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RemW = LenW + 2;

  logic              vld_s  [SqrtSteps+1];
  logic [SumW-1:0]   n_s    [SqrtSteps+1];
  logic [LenW-1:0]   root_s [SqrtSteps+1];
  logic [RemW-1:0]   rem_s  [SqrtSteps+1];
  logic [SIDE_W-1:0] side_s [SqrtSteps+1];

  assign vld_s[0]  = vld_i;
  assign n_s[0]    = n_i;
  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    logic [RemW+1:0] cand;
    logic [RemW+1:0] trial;
    logic            ge;

    // Bring down the next two radicand bits and try root*4+1.
    assign cand  = {rem_s[i], n_s[i][SumW-1 -: 2]};
    assign trial = {2'b00, root_s[i], 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      n_s[i+1]    <= {n_s[i][SumW-3:0], 2'b00};
      root_s[i+1] <= {root_s[i][LenW-2:0], ge};
      rem_s[i+1]  <= ge ? RemW'(cand - trial) : cand[RemW-1:0];
      side_s[i+1] <= side_s[i];
    end
  end

  assign vld_o  = vld_s[SqrtSteps];
  assign root_o = root_s[SqrtSteps];
  assign side_o = side_s[SqrtSteps];

endmodule

### rtl/core/prdg_div.sv
// ----------------------------------------------------------------------------
// prdg_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
module prdg_div
  import prdg_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [LenW-1:0]            den_i,
  input  logic [2:0][NumW-1:0]       num_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       vld_o,
  output logic [2:0][QuotW-1:0]      quot_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic                  vld_s  [DivSteps+1];
  logic [LenW-1:0]       den_s  [DivSteps+1];
  logic [2:0][NumW-1:0]  rem_s  [DivSteps+1];
  logic [2:0][QuotW-1:0] quot_s [DivSteps+1];
  logic [SIDE_W-1:0]     side_s [DivSteps+1];

  assign vld_s[0]  = vld_i;
  assign den_s[0]  = den_i;
  assign rem_s[0]  = num_i;
  assign quot_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int Bit = DivSteps - 1 - i;
    logic [NumW-1:0]       sub;
    logic [2:0][NumW-1:0]  rem_d;
    logic [2:0][QuotW-1:0] quot_d;

    assign sub = NumW'(den_s[i]) << Bit;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_d[l]  = rem_s[i][l];
        quot_d[l] = quot_s[i][l];
        if (rem_s[i][l] >= sub) begin
          rem_d[l]       = rem_s[i][l] - sub;
          quot_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      den_s[i+1]  <= den_s[i];
      rem_s[i+1]  <= rem_d;
      quot_s[i+1] <= quot_d;
      side_s[i+1] <= side_s[i];
    end
  end

  assign vld_o  = vld_s[DivSteps];
  assign quot_o = quot_s[DivSteps];
  assign side_o = side_s[DivSteps];

endmodule

### rtl/core/pinhole_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// pinhole_ray_direction_generator
// Maps a pixel coordinate to the world-space unit direction of its primary ray.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  pixel     start, busy, item_i                      in, taken when start & !busy
//  ray       done_o, result_o                         out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,    APB, 64-bit registers
//            prdata, pready                           at 8*index
//
// Every item passes a fixed pipeline of 52 register stages: six for the
// coordinate, scale and square terms, 25 for the one-bit-a-stage square root,
// one to form the dividends, 17 for the one-bit-a-stage divider and three for
// the rotation. busy stays low, so one item is taken every cycle. Reset clears
// the valid bits and loads the registers with an identity rotation. The
// receiver cannot stall the output.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_generator
  import prdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pix_t        item_i,
  output logic        done_o,
  output dir_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [47:0] rot_q [3];
  logic [15:0] scale_x_q, scale_y_q;
  logic [17:0] step_x_q, step_y_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]  <= RotXReset;
      rot_q[1]  <= RotYReset;
      rot_q[2]  <= RotZReset;
      scale_x_q <= ScaleReset;
      scale_y_q <= ScaleReset;
      step_x_q  <= StepReset;
      step_y_q  <= StepReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRotX:   rot_q[0]  <= pwdata[47:0];
        RegRotY:   rot_q[1]  <= pwdata[47:0];
        RegRotZ:   rot_q[2]  <= pwdata[47:0];
        RegScaleX: scale_x_q <= pwdata[15:0];
        RegScaleY: scale_y_q <= pwdata[15:0];
        RegStepX:  step_x_q  <= pwdata[17:0];
        RegStepY:  step_y_q  <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRotX:   prdata = {16'd0, rot_q[0]};
      RegRotY:   prdata = {16'd0, rot_q[1]};
      RegRotZ:   prdata = {16'd0, rot_q[2]};
      RegScaleX: prdata = {48'd0, scale_x_q};
      RegScaleY: prdata = {48'd0, scale_y_q};
      RegStepX:  prdata = {46'd0, step_x_q};
      RegStepY:  prdata = {46'd0, step_y_q};
      default:   prdata = '0;
    endcase
  end

  // Stage A: pixel times step.
  logic        a_vld_q;
  logic [29:0] a_px_q, a_py_q;

  // Stage B: device coordinates, saturated above +1.0.
  logic               b_vld_q;
  logic signed [17:0] b_cx_q, b_cy_q;
  logic signed [30:0] cx_w, cy_w;

  // Stage C: coordinate times scale.
  logic               c_vld_q;
  logic signed [34:0] c_tx_q, c_ty_q;

  // Stage D: view-space magnitudes and signs, Q.20.
  logic            d_vld_q;
  logic            d_sx_q, d_sy_q;
  logic [MagW-1:0] d_mx_q, d_my_q;
  logic [34:0]     abs_tx, abs_ty;

  // Stage E: squares.
  logic            e_vld_q;
  logic            e_sx_q, e_sy_q;
  logic [MagW-1:0] e_mx_q, e_my_q;
  logic [47:0]     e_qx_q, e_qy_q;

  // Stage F: sum of squares, vz^2 is 2^40.
  logic            f_vld_q;
  logic            f_sx_q, f_sy_q;
  logic [MagW-1:0] f_mx_q, f_my_q;
  logic [SumW-1:0] f_sum_q;

  always_comb begin
    cx_w   = $signed({1'b0, a_px_q}) - 31'sd65536;
    cy_w   = $signed({1'b0, a_py_q}) - 31'sd65536;
    abs_tx = c_tx_q[34] ? 35'(-c_tx_q) : 35'(c_tx_q);
    abs_ty = c_ty_q[34] ? 35'(-c_ty_q) : 35'(c_ty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start & ~busy;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q  <= 30'(item_i.pixel_x * step_x_q);
    a_py_q  <= 30'(item_i.pixel_y * step_y_q);
    b_cx_q  <= (cx_w > 31'sd65536) ? 18'sd65536 : cx_w[17:0];
    b_cy_q  <= (cy_w > 31'sd65536) ? 18'sd65536 : cy_w[17:0];
    c_tx_q  <= b_cx_q * $signed({1'b0, scale_x_q});
    c_ty_q  <= b_cy_q * $signed({1'b0, scale_y_q});
    // Round half away from zero from Q.28 to Q.20.
    d_sx_q  <= c_tx_q[34];
    d_sy_q  <= c_ty_q[34];
    d_mx_q  <= MagW'((abs_tx + 35'd128) >> 8);
    d_my_q  <= MagW'((abs_ty + 35'd128) >> 8);
    e_sx_q  <= d_sx_q;
    e_sy_q  <= d_sy_q;
    e_mx_q  <= d_mx_q;
    e_my_q  <= d_my_q;
    e_qx_q  <= d_mx_q * d_mx_q;
    e_qy_q  <= d_my_q * d_my_q;
    f_sx_q  <= e_sx_q;
    f_sy_q  <= e_sy_q;
    f_mx_q  <= e_mx_q;
    f_my_q  <= e_my_q;
    f_sum_q <= SumW'(e_qx_q) + SumW'(e_qy_q) + (SumW'(1) << 40);
  end

  // Length of the view-space vector.
  localparam int SqSideW = 2 + 2 * MagW;
  logic               s_vld;
  logic [LenW-1:0]    s_len;
  logic [SqSideW-1:0] s_side;

  prdg_sqrt #(
    .SIDE_W(SqSideW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld_q),
    .n_i    (f_sum_q),
    .side_i ({f_sx_q, f_sy_q, f_mx_q, f_my_q}),
    .vld_o  (s_vld),
    .root_o (s_len),
    .side_o (s_side)
  );

  // Dividends |v|*2^16 + len/2 give the rounded quotient directly.
  logic                 p_vld_q;
  logic [1:0]           p_sign_q;
  logic [LenW-1:0]      p_len_q;
  logic [2:0][NumW-1:0] p_num_q;
  logic [NumW-1:0]      half_len;

  assign half_len = NumW'(s_len >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p_sign_q   <= s_side[SqSideW-1 -: 2];
    p_len_q    <= s_len;
    p_num_q[0] <= NumW'({s_side[2*MagW-1 -: MagW], 16'd0}) + half_len;
    p_num_q[1] <= NumW'({s_side[MagW-1:0], 16'd0}) + half_len;
    p_num_q[2] <= (NumW'(1) << 36) + half_len;
  end

  logic                  q_vld;
  logic [1:0]            q_sign;
  logic [2:0][QuotW-1:0] q_mag;

  prdg_div #(
    .SIDE_W(2)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (p_vld_q),
    .den_i  (p_len_q),
    .num_i  (p_num_q),
    .side_i (p_sign_q),
    .vld_o  (q_vld),
    .quot_o (q_mag),
    .side_o (q_sign)
  );

  // Rotation: nine products, then row sums, then rounding and saturation.
  logic signed [QuotW:0]  unit [3];
  logic                   m_vld_q;
  logic signed [33:0]     m_prod_q [3][3];
  logic                   r_vld_q;
  logic signed [35:0]     r_acc_q [3];
  logic                   o_vld_q;
  logic signed [15:0]     o_dir_q [3];
  logic [35:0]            acc_mag [3];
  logic [19:0]            acc_rnd [3];
  logic [15:0]            acc_sat [3];

  always_comb begin
    unit[0] = q_sign[1] ? -$signed({1'b0, q_mag[0]}) : $signed({1'b0, q_mag[0]});
    unit[1] = q_sign[0] ? -$signed({1'b0, q_mag[1]}) : $signed({1'b0, q_mag[1]});
    unit[2] = -$signed({1'b0, q_mag[2]});
    for (int r = 0; r < 3; r++) begin
      acc_mag[r] = r_acc_q[r][35] ? 36'(-r_acc_q[r]) : 36'(r_acc_q[r]);
      acc_rnd[r] = 20'((acc_mag[r] + 36'd32768) >> 16);
      acc_sat[r] = (acc_rnd[r] > 20'd16384) ? 16'd16384 : acc_rnd[r][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      m_vld_q <= q_vld;
      r_vld_q <= m_vld_q;
      o_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_prod_q[r][c] <= $signed(rot_q[r][16*c +: 16]) * unit[c];
      end
      r_acc_q[r] <= 36'(m_prod_q[r][0]) + 36'(m_prod_q[r][1]) + 36'(m_prod_q[r][2]);
      o_dir_q[r] <= r_acc_q[r][35] ? -$signed(acc_sat[r]) : $signed(acc_sat[r]);
    end
  end

  assign done_o         = o_vld_q;
  assign result_o.dir_x = o_dir_q[0];
  assign result_o.dir_y = o_dir_q[1];
  assign result_o.dir_z = o_dir_q[2];

endmodule

### rtl/core/prdg_checker.sv
// ----------------------------------------------------------------------------
// prdg_checker
// Port-level checks of the ray direction generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "pinhole_ray_direction_generator_macros.svh"

module prdg_checker
  import prdg_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input dir_t result_o,
  input logic pready
);

  logic in_range;

  assign in_range = (result_o.dir_x <= 16'sd16384) && (result_o.dir_x >= -16'sd16384) &&
                    (result_o.dir_y <= 16'sd16384) && (result_o.dir_y >= -16'sd16384) &&
                    (result_o.dir_z <= 16'sd16384) && (result_o.dir_z >= -16'sd16384);

  // Every taken item comes out after the fixed pipeline depth.
  `PRDG_ASSERT(a_item_out, (start && !busy) |-> ##Latency done_o, "item result missing")

  // No result appears without an item taken the fixed pipeline depth before it.
  `PRDG_ASSERT(a_no_extra, done_o |-> ($past(start && !busy, Latency) && $past(rst_ni, Latency)), "unexpected result")

  // A unit direction component never leaves [-1, +1].
  `PRDG_ASSERT(a_range, done_o |-> in_range, "component out of range")

  `PRDG_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind pinhole_ray_direction_generator prdg_checker u_prdg_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o),
  .pready   (pready)
);

### tb/sv/pinhole_ray_direction_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_direction_generator_tb
// Sends pixel coordinates under a series of camera settings written over the
// register port and checks every ray direction against a fixed-point
// predictor of the pinhole unprojection, normalization and rotation.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_generator_tb;
  import prdg_pkg::*;

  localparam int IdleLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pix_t        item_i;
  logic        done_o;
  dir_t        result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  pinhole_ray_direction_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the camera registers.
  logic [47:0] cam_rot [3];
  logic [15:0] cam_scale_x, cam_scale_y;
  logic [17:0] cam_step_x, cam_step_y;

  dir_t ray_queue[$];
  int   error_count;
  int   idle_cycles;
  int   burst_left;
  int   view_w, view_h;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint round_shift(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Pixel index to device coordinate in Q.16, clipped at +1.0.
  function automatic longint device_coord(logic [CoordBits-1:0] pix, logic [17:0] stp);
    longint c;
    c = longint'(pix) * longint'(stp) - 65536;
    return (c > 65536) ? 64'sd65536 : c;
  endfunction

  function automatic logic [15:0] rotate_row(logic [47:0] row, longint u [3]);
    longint acc;
    longint r;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += longint'($signed(row[16*k +: 16])) * u[k];
    r = round_shift(acc, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic dir_t ray_direction(pix_t p);
    longint v [3];
    longint u [3];
    longint unsigned sum;
    longint unsigned m;
    longint len;
    dir_t d;
    v[0] = round_shift(device_coord(p.pixel_x, cam_step_x) * longint'(cam_scale_x), 8);
    v[1] = round_shift(device_coord(p.pixel_y, cam_step_y) * longint'(cam_scale_y), 8);
    v[2] = -1048576;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m = (v[k] < 0) ? longint'(-v[k]) : v[k];
      sum += m * m;
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) u[k] = round_div(v[k] * 65536, len);
    d.dir_x = rotate_row(cam_rot[0], u);
    d.dir_y = rotate_row(cam_rot[1], u);
    d.dir_z = rotate_row(cam_rot[2], u);
    return d;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, $signed(want), $signed(got),
             $realtime);
    error_count++;
  endtask

  // Result checking and the stall watchdog.
  always @(posedge clk_i) begin
    dir_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (ray_queue.size() == 0) begin
          $display("unexpected ray at %0t", $realtime);
          error_count++;
        end else begin
          want = ray_queue.pop_front();
          if (result_o.dir_x !== want.dir_x) report_mismatch("dir_x", want.dir_x, result_o.dir_x);
          if (result_o.dir_y !== want.dir_y) report_mismatch("dir_y", want.dir_y, result_o.dir_y);
          if (result_o.dir_z !== want.dir_z) report_mismatch("dir_z", want.dir_z, result_o.dir_z);
        end
      end
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    pix_t p;
    p.pixel_x = px;
    p.pixel_y = py;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      // Some bursts are long, giving stretches with no idling.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
    start  <= 1'b1;
    item_i <= p;
    do @(posedge clk_i); while (busy);
    ray_queue.push_back(ray_direction(p));
    burst_left--;
  endtask

  // Stop sending and wait until the pipeline is empty.
  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (ray_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegRotX:   cam_rot[0]  = value[47:0];
      RegRotY:   cam_rot[1]  = value[47:0];
      RegRotZ:   cam_rot[2]  = value[47:0];
      RegScaleX: cam_scale_x = value[15:0];
      RegScaleY: cam_scale_y = value[15:0];
      RegStepX:  cam_step_x  = value[17:0];
      RegStepY:  cam_step_y  = value[17:0];
      default: ;
    endcase
  endtask

  task automatic write_camera(logic [47:0] rx, logic [47:0] ry, logic [47:0] rz,
                              logic [15:0] sx, logic [15:0] sy,
                              logic [17:0] tx, logic [17:0] ty);
    write_reg(RegRotX, 64'(rx));
    write_reg(RegRotY, 64'(ry));
    write_reg(RegRotZ, 64'(rz));
    write_reg(RegScaleX, 64'(sx));
    write_reg(RegScaleY, 64'(sy));
    write_reg(RegStepX, 64'(tx));
    write_reg(RegStepY, 64'(ty));
  endtask

  task automatic test_reset_camera;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd256, 12'd256);
    // Far past the viewport the device coordinate clips at +1.0.
    send_pixel(12'd512, 12'd2048);
    send_pixel(12'hAAA, 12'h555);
    drain();
  endtask

  task automatic test_step_extremes;
    // Zero step holds the coordinate at -1.0; a step above 2.0 clips at once.
    write_camera(RotXReset, RotYReset, RotZReset, 16'hFFFF, 16'd0, 18'd0, 18'h3FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd1);
    send_pixel(12'd1234, 12'd4095);
    drain();
    write_camera(RotXReset, RotYReset, RotZReset, 16'd0, 16'hFFFF, 18'd1, 18'd131072);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2048, 12'd2);
    drain();
  endtask

  task automatic test_skewed_rotation;
    // Rows far from orthonormal drive the outputs into saturation.
    write_camera(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
                 16'hFFFF, 16'hFFFF, 18'd64, 18'd64);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();
  endtask

  function automatic logic [47:0] random_row(int axis);
    logic [47:0] row;
    if ($urandom_range(0, 1) == 0) begin
      row = 48'({$urandom(), $urandom()});
    end else begin
      row = '0;
      row[16*axis +: 16] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end
    return row;
  endfunction

  function automatic logic [17:0] random_step(output int extent);
    extent = $urandom_range(1, 4096);
    if ($urandom_range(0, 7) == 0) return 18'($urandom_range(0, 18'h3FFFF));
    return 18'((131072 + extent / 2) / extent);
  endfunction

  task automatic test_random_cameras;
    logic [17:0] tx, ty;
    for (int phase = 0; phase < 7; phase++) begin
      tx = random_step(view_w);
      ty = random_step(view_h);
      write_camera(random_row(0), random_row(1), random_row(2),
                   16'($urandom_range(0, 3) ? $urandom_range(800, 8000)
                                            : $urandom_range(0, 65535)),
                   16'($urandom_range(0, 3) ? $urandom_range(800, 8000)
                                            : $urandom_range(0, 65535)),
                   tx, ty);
      for (int n = 0; n < 245; n++) begin
        if ($urandom_range(0, 4) == 0) send_pixel(12'($urandom()), 12'($urandom()));
        else send_pixel(12'($urandom_range(0, view_w - 1)),
                        12'($urandom_range(0, view_h - 1)));
        // Once, midway through one phase, wait for every ray in flight before going on.
        if (n == 120 && phase == 2) drain();
      end
      drain();
    end
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    burst_left  = 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cam_rot[0]  = RotXReset;
    cam_rot[1]  = RotYReset;
    cam_rot[2]  = RotZReset;
    cam_scale_x = ScaleReset;
    cam_scale_y = ScaleReset;
    cam_step_x  = StepReset;
    cam_step_y  = StepReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_camera();
    test_step_extremes();
    test_skewed_rotation();
    test_random_cameras();
    if (error_count == 0 && ray_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### pinhole_ray_direction_generator.f
+incdir+rtl/core
rtl/core/prdg_pkg.sv
rtl/core/prdg_sqrt.sv
rtl/core/prdg_div.sv
rtl/core/pinhole_ray_direction_generator.sv
rtl/core/prdg_checker.sv
tb/sv/pinhole_ray_direction_generator_tb.sv
